FILE: rtl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types, constants and the FIR coefficient table of the PDM decimator.
// ----------------------------------------------------------------------------
package pbd_pkg;

	localparam int PBD_BYTE_W    = 8;
	localparam int PBD_FACTOR_W  = 9;
	localparam int PBD_ONES_W    = 9;
	localparam int PBD_PHASE_W   = 8;
	localparam int PBD_SAMPLE_W  = 15;
	localparam int PBD_COEF_W    = 15;
	localparam int PBD_PROD_W    = PBD_SAMPLE_W + PBD_COEF_W;
	localparam int PBD_DIV_NUM_W = PBD_ONES_W + PBD_SAMPLE_W;
	localparam int PBD_DIV_CNT_W = 5;
	localparam int PBD_FRAC_W    = 16;

	localparam logic [PBD_FACTOR_W-1:0] PBD_FACTOR_RESET = 9'd64;
	localparam logic [PBD_FACTOR_W-1:0] PBD_FACTOR_MAX   = 9'd256;
	localparam logic [PBD_SAMPLE_W-1:0] PBD_SAMPLE_MAX   = 15'h7FFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIT,
		ST_DIV,
		ST_HWRITE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} pbd_state_t;

	typedef struct packed {
		logic load;       // item accepted
		logic bit_step;   // consume one PDM bit
		logic hist_write; // push raw sample into history
		logic mac_issue;  // issue one tap read
		logic emit;       // load the output register
	} pbd_cmd_t;

	typedef struct packed {
		logic trigger;    // current bit completes a sample
		logic bit_last;   // current bit is bit 0
		logic more_bits;  // bits remain after the triggering bit
		logic div_done;
		logic last_tap;
		logic pipe_busy;
		logic out_free;
	} pbd_stat_t;

	// Q0.16 taps: rising half, then mirrored; pattern repeats every 16 taps
	function automatic logic [PBD_COEF_W-1:0] pbd_coef(input logic [3:0] k);
		logic [2:0] h;
		logic [PBD_COEF_W-1:0] c;
		h = k[3] ? ~k[2:0] : k[2:0];
		case (h)
			3'd0: c = 15'd328;
			3'd1: c = 15'd655;
			3'd2: c = 15'd1638;
			3'd3: c = 15'd3277;
			3'd4: c = 15'd6554;
			3'd5: c = 15'd9830;
			3'd6: c = 15'd13107;
			3'd7: c = 15'd16384;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/pbd_ifs.sv
// ----------------------------------------------------------------------------
// pbd_ifs
// Valid/ready channels of the PDM decimator: PDM input, PCM output, config.
// ----------------------------------------------------------------------------
interface pbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pdm_data;
	logic       block_start;

	modport source (output valid, output pdm_data, output block_start, input ready);
	modport sink   (input valid, input pdm_data, input block_start, output ready);
endinterface

interface pbd_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] pcm_sample;
	logic        last_of_run;

	modport source (output valid, output pcm_sample, output last_of_run, input ready);
	modport sink   (input valid, input pcm_sample, input last_of_run, output ready);
endinterface

interface pbd_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] decim_factor;

	modport source (output valid, output decim_factor, input ready);
	modport sink   (input valid, input decim_factor, output ready);
endinterface

FILE: rtl/pbd_ram.sv
// ----------------------------------------------------------------------------
// pbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbd_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/pbd_div.sv
// ----------------------------------------------------------------------------
// pbd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbd_div
	import pbd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [PBD_DIV_NUM_W-1:0] num,
	input  logic [PBD_FACTOR_W-1:0]  den,
	output logic [PBD_DIV_NUM_W-1:0] quot,
	output logic                     busy,
	output logic                     done
);

	logic [PBD_DIV_CNT_W-1:0] cnt_q;
	logic [PBD_FACTOR_W:0]    rem_q;
	logic [PBD_DIV_NUM_W-1:0] quo_q;
	logic [PBD_FACTOR_W-1:0]  den_q;
	logic                     done_q;
	logic [PBD_FACTOR_W:0]    rem_sh;
	logic                     fits;

	// remainder stays below den, so shifting in one bit never overflows
	assign rem_sh = {rem_q[PBD_FACTOR_W-1:0], quo_q[PBD_DIV_NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= PBD_DIV_CNT_W'(PBD_DIV_NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == PBD_DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[PBD_DIV_NUM_W-2:0], fits};
		end
	end

	assign quot = quo_q;
	assign busy = cnt_q != '0;
	assign done = done_q;

endmodule

FILE: rtl/pbd_dp.sv
// ----------------------------------------------------------------------------
// pbd_dp
// Datapath: bit counter, sample divider, circular tap history, shared MAC,
// output register and the decimation factor register.
// ----------------------------------------------------------------------------
module pbd_dp
	import pbd_pkg::*;
#(
	parameter int TAP_COUNT = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	pbd_in_if.sink        pdm,
	pbd_out_if.source     pcm,
	pbd_cfg_if.sink       cfg,
	input  pbd_cmd_t      cmd,
	output pbd_stat_t     stat
);

	localparam int TW    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
	localparam int ACC_W = PBD_PROD_W + TW + 1;
	localparam logic [TW-1:0] TAP_LAST = TW'(TAP_COUNT - 1);

	// configuration
	logic [PBD_FACTOR_W-1:0] factor_q;
	logic [PBD_FACTOR_W-1:0] eff_factor;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= PBD_FACTOR_RESET;
		end else if (cfg.valid) begin
			factor_q <= cfg.decim_factor;
		end
	end

	always_comb begin
		if (factor_q == '0) begin
			eff_factor = PBD_FACTOR_W'(1);
		end else if (factor_q > PBD_FACTOR_MAX) begin
			eff_factor = PBD_FACTOR_MAX;
		end else begin
			eff_factor = factor_q;
		end
	end

	// bit scan
	logic [PBD_BYTE_W-1:0]   byte_q;
	logic [2:0]              bit_idx_q;
	logic [PBD_ONES_W-1:0]   ones_q;
	logic [PBD_PHASE_W-1:0]  phase_q;
	logic                    last_q;
	logic                    more_q;
	logic [PBD_ONES_W-1:0]   ones_nxt;
	logic                    trigger;
	logic                    div_start;

	assign ones_nxt  = ones_q + PBD_ONES_W'(byte_q[bit_idx_q]);
	assign trigger   = (PBD_FACTOR_W'(phase_q) + PBD_FACTOR_W'(1)) >= eff_factor;
	assign div_start = cmd.bit_step & trigger;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ones_q  <= '0;
			phase_q <= '0;
		end else if (cmd.load) begin
			if (pdm.block_start) begin
				ones_q  <= '0;
				phase_q <= '0;
			end
		end else if (cmd.bit_step) begin
			ones_q  <= trigger ? '0 : ones_nxt;
			phase_q <= trigger ? '0 : phase_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q    <= pdm.pdm_data;
			bit_idx_q <= 3'd7;
		end else if (cmd.bit_step) begin
			bit_idx_q <= bit_idx_q - 1'b1;
			more_q    <= bit_idx_q != 3'd0;
			if (trigger) begin
				// another sample in this byte needs at least eff_factor more bits
				last_q <= PBD_FACTOR_W'(bit_idx_q) < eff_factor;
			end
		end
	end

	// raw sample = ones * 32767 / factor
	logic [PBD_DIV_NUM_W-1:0] div_num;
	logic [PBD_DIV_NUM_W-1:0] div_quot;
	logic                     div_busy;
	logic                     div_done;
	logic [PBD_SAMPLE_W-1:0]  raw_sample;

	assign div_num = {ones_nxt, {PBD_SAMPLE_W{1'b0}}} - PBD_DIV_NUM_W'(ones_nxt);

	pbd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (eff_factor),
		.quot   (div_quot),
		.busy   (div_busy),
		.done   (div_done)
	);

	assign raw_sample = (|div_quot[PBD_DIV_NUM_W-1:PBD_SAMPLE_W]) ? PBD_SAMPLE_MAX
		: div_quot[PBD_SAMPLE_W-1:0];

	// tap history, newest at rd start, walked backward
	logic [TW-1:0]           wr_ptr_q;
	logic [TW-1:0]           rd_ptr_q;
	logic [TW-1:0]           tap_q;
	logic [TAP_COUNT-1:0]    hvalid_q;
	logic [PBD_SAMPLE_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
			wr_ptr_q <= '0;
		end else if (cmd.load && pdm.block_start) begin
			hvalid_q <= '0;
		end else if (cmd.hist_write) begin
			hvalid_q[wr_ptr_q] <= 1'b1;
			wr_ptr_q <= (wr_ptr_q == TAP_LAST) ? '0 : wr_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hist_write) begin
			rd_ptr_q <= wr_ptr_q;
			tap_q    <= '0;
		end else if (cmd.mac_issue) begin
			rd_ptr_q <= (rd_ptr_q == '0) ? TAP_LAST : rd_ptr_q - 1'b1;
			tap_q    <= (tap_q == TAP_LAST) ? '0 : tap_q + 1'b1;
		end
	end

	pbd_ram #(
		.WIDTH (PBD_SAMPLE_W),
		.DEPTH (TAP_COUNT)
	) u_hist (
		.clk   (clk),
		.we    (cmd.hist_write),
		.waddr (wr_ptr_q),
		.wdata (raw_sample),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// MAC pipeline: read -> multiply -> accumulate
	logic                    rd_vld_s1;
	logic                    hv_s1;
	logic [TW-1:0]           tap_s1;
	logic [6:0]              tap_ext;
	logic [PBD_SAMPLE_W-1:0] hist_s1;
	logic [PBD_COEF_W-1:0]   coef_s1;
	logic                    prod_vld_s2;
	logic [PBD_PROD_W-1:0]   prod_s2;
	logic [ACC_W-1:0]        acc_q;
	logic [PBD_SAMPLE_W-1:0] filt_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			prod_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1   <= cmd.mac_issue;
			prod_vld_s2 <= rd_vld_s1;
		end
	end

	assign tap_ext = 7'(tap_s1);
	assign hist_s1 = hv_s1 ? ram_rdata : '0;
	assign coef_s1 = pbd_coef(tap_ext[3:0]);

	always_ff @(posedge clk) begin
		hv_s1   <= hvalid_q[rd_ptr_q];
		tap_s1  <= tap_q;
		prod_s2 <= hist_s1 * coef_s1;
		if (cmd.hist_write) begin
			acc_q <= '0;
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign filt_sample = (|acc_q[ACC_W-1:PBD_FRAC_W+PBD_SAMPLE_W]) ? PBD_SAMPLE_MAX
		: acc_q[PBD_FRAC_W+PBD_SAMPLE_W-1:PBD_FRAC_W];

	// output register
	logic                    out_valid_q;
	logic [PBD_SAMPLE_W-1:0] out_sample_q;
	logic                    out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (pcm.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_sample_q <= filt_sample;
			out_last_q   <= last_q;
		end
	end

	assign pcm.valid       = out_valid_q;
	assign pcm.pcm_sample  = out_sample_q;
	assign pcm.last_of_run = out_last_q;

	assign stat.trigger   = trigger;
	assign stat.bit_last  = bit_idx_q == 3'd0;
	assign stat.more_bits = more_q;
	assign stat.div_done  = div_done;
	assign stat.last_tap  = tap_q == TAP_LAST;
	assign stat.pipe_busy = rd_vld_s1 | prod_vld_s2;
	assign stat.out_free  = !out_valid_q || pcm.ready;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || pcm.ready))
		else $error("output register overwritten");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist_write |-> !(rd_vld_s1 || prod_vld_s2))
		else $error("history written during MAC");

endmodule

FILE: rtl/pbd_ctrl.sv
// ----------------------------------------------------------------------------
// pbd_ctrl
// Sequencer: bit scan, divide, history push, tap walk, result hand-off.
// ----------------------------------------------------------------------------
module pbd_ctrl
	import pbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pbd_in_if.sink    pdm,
	input  pbd_stat_t stat,
	output pbd_cmd_t  cmd
);

	pbd_state_t state_q;
	pbd_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pdm.valid) state_nxt = ST_BIT;
			end
			ST_BIT: begin
				if (stat.trigger) state_nxt = ST_DIV;
				else if (stat.bit_last) state_nxt = ST_IDLE;
			end
			ST_DIV: begin
				if (stat.div_done) state_nxt = ST_HWRITE;
			end
			ST_HWRITE: begin
				state_nxt = ST_MAC;
			end
			ST_MAC: begin
				if (stat.last_tap) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) state_nxt = stat.more_bits ? ST_BIT : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		pdm.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pdm.ready = 1'b1;
				cmd.load  = pdm.valid;
			end
			ST_BIT:    cmd.bit_step   = 1'b1;
			ST_HWRITE: cmd.hist_write = 1'b1;
			ST_MAC:    cmd.mac_issue  = 1'b1;
			ST_EMIT:   cmd.emit       = stat.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_load_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.bit_step)
		else $error("accepted item not scanned");
	a_write_mac: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist_write |=> cmd.mac_issue)
		else $error("MAC did not follow history write");
	a_mac_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mac_issue && stat.last_tap) |=> !cmd.mac_issue)
		else $error("tap walk overran");

endmodule

FILE: rtl/pdm_boxcar_decimator_fir_unit.sv
// ----------------------------------------------------------------------------
// pdm_boxcar_decimator_fir_unit
// PDM byte in, boxcar decimation, TAP_COUNT-tap FIR, saturated PCM out.
// ----------------------------------------------------------------------------
// A byte that forms no sample is accepted, then its PDM bits are scanned in turn.
// Each sample formed adds the bit-serial divide, one history write, TAP_COUNT tap
// reads through the shared MAC, the pipeline drain and the output register load,
// which waits while that register is still full. A new byte is taken once the
// byte's remaining bits are scanned and its last result sits in the output register.
// Reset clears control state and history valid bits; decim_factor returns to 64.
module pdm_boxcar_decimator_fir_unit
	import pbd_pkg::*;
#(
	parameter int TAP_COUNT = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	pbd_in_if.sink    pdm,
	pbd_out_if.source pcm,
	pbd_cfg_if.sink   cfg
);

	pbd_cmd_t  cmd;
	pbd_stat_t stat;

	pbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.pdm    (pdm),
		.stat   (stat),
		.cmd    (cmd)
	);

	pbd_dp #(
		.TAP_COUNT (TAP_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.pdm    (pdm),
		.pcm    (pcm),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

FILE: tb/tb_pdm_boxcar_decimator_fir_unit.sv
// ----------------------------------------------------------------------------
// tb_pdm_boxcar_decimator_fir_unit
// Drives PDM bytes and decimation factors into the decimator, predicts every
// filtered PCM sample in a local model and compares each one as it leaves.
// ----------------------------------------------------------------------------
module tb_pdm_boxcar_decimator_fir_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAPS = 32;

	// Predicts filtered PCM samples and holds the ones not yet seen at the output
	class pcm_predictor;
		typedef struct packed {
			logic [14:0] sample;
			logic        last;
		} pcm_item_t;

		logic [8:0]  factor;
		logic [8:0]  ones_seen;
		logic [7:0]  bits_seen;
		logic [14:0] raw_taps [TAPS];
		pcm_item_t   pcm_due [$];
		int          errors;

		function new();
			factor = pbd_pkg::PBD_FACTOR_RESET;
			clear_run();
			errors = 0;
		endfunction

		function void clear_run();
			ones_seen = '0;
			bits_seen = '0;
			foreach (raw_taps[j]) raw_taps[j] = '0;
		endfunction

		function logic [14:0] tap_weight(input int j);
			int k;
			k = j % 16;
			if (k >= 8) k = 15 - k;
			case (k)
				0: return 15'd328;
				1: return 15'd655;
				2: return 15'd1638;
				3: return 15'd3277;
				4: return 15'd6554;
				5: return 15'd9830;
				6: return 15'd13107;
				default: return 15'd16384;
			endcase
		endfunction

		function void set_factor(input logic [8:0] v);
			factor = v;
		endfunction

		function void accept_pdm(input logic [7:0] pdm_bits, input logic start);
			int unsigned eff;
			int unsigned raw;
			logic [47:0] acc;
			int          first;
			pcm_item_t   item;
			eff = (factor == 0) ? 1 : ((factor > 256) ? 256 : factor);
			first = pcm_due.size();
			if (start) clear_run();
			for (int i = 7; i >= 0; i--) begin
				ones_seen = ones_seen + pdm_bits[i];
				if (bits_seen + 1 >= eff) begin
					raw = ones_seen * 32767 / eff;
					if (raw > 32767) raw = 32767;
					for (int j = TAPS - 1; j > 0; j--) raw_taps[j] = raw_taps[j-1];
					raw_taps[0] = raw[14:0];
					acc = '0;
					for (int j = 0; j < TAPS; j++) acc = acc + raw_taps[j] * tap_weight(j);
					acc = acc >> 16;
					item.sample = (acc > 32767) ? 15'h7FFF : acc[14:0];
					item.last = 1'b0;
					pcm_due.push_back(item);
					ones_seen = '0;
					bits_seen = '0;
				end else begin
					bits_seen = bits_seen + 8'd1;
				end
			end
			if (pcm_due.size() > first) pcm_due[pcm_due.size()-1].last = 1'b1;
		endfunction

		function void check_pcm(input logic [14:0] sample, input logic last);
			pcm_item_t exp_item;
			if (pcm_due.size() == 0) begin
				$error("unexpected item: pcm_sample %0d last_of_run %0d", sample, last);
				errors++;
				return;
			end
			exp_item = pcm_due.pop_front();
			if (exp_item.sample !== sample) begin
				$error("pcm_sample: expected %0d, actual %0d", exp_item.sample, sample);
				errors++;
			end
			if (exp_item.last !== last) begin
				$error("last_of_run: expected %0d, actual %0d", exp_item.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pbd_in_if  pdm();
	pbd_out_if pcm();
	pbd_cfg_if cfg();

	pdm_boxcar_decimator_fir_unit #(
		.TAP_COUNT(TAPS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pdm   (pdm),
		.pcm   (pcm),
		.cfg   (cfg)
	);

	pcm_predictor pcm_pred = new();
	int rx_idle_pct   = 0;
	int rx_hold_cycles = 0;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg.valid && cfg.ready) pcm_pred.set_factor(cfg.decim_factor);
			if (pdm.valid && pdm.ready) pcm_pred.accept_pdm(pdm.pdm_data, pdm.block_start);
			if (pcm.valid && pcm.ready) pcm_pred.check_pcm(pcm.pcm_sample, pcm.last_of_run);
		end
	end

	// PCM receiver: ready runs, short stalls, and a long hold on request
	initial begin
		int n;
		pcm.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
				pcm.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < rx_idle_pct) begin
				n = $urandom_range(1, 12);
				pcm.ready <= 1'b0;
			end else begin
				n = $urandom_range(1, 16);
				pcm.ready <= 1'b1;
			end
			repeat (n) @(posedge clk);
		end
	end

	task automatic send_pdm(input logic [7:0] pdm_bits, input logic start);
		pdm.valid       <= 1'b1;
		pdm.pdm_data    <= pdm_bits;
		pdm.block_start <= start;
		do @(posedge clk); while (pdm.ready !== 1'b1);
	endtask

	task automatic pdm_gap(input int n);
		pdm.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// a byte that forms no sample may still be in flight when the queue empties
	task automatic wait_pcm_drained(input int settle);
		pdm.valid <= 1'b0;
		do @(posedge clk); while (pcm_pred.pcm_due.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_factor(input logic [8:0] v);
		cfg.valid        <= 1'b1;
		cfg.decim_factor <= v;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
	endtask

	task automatic run_random_phase(input logic [8:0] factor, input int n_items,
			input int idle_pct, input bit long_hold, input bit drain_pause);
		int          density;
		int          kind;
		logic [7:0]  pdm_bits;
		wait_pcm_drained(20);
		write_factor(factor);
		rx_idle_pct = idle_pct;
		density = $urandom_range(0, 16);
		for (int i = 0; i < n_items; i++) begin
			if (i % 11 == 0) density = $urandom_range(0, 16);
			if (long_hold && i == 10) rx_hold_cycles = 600;
			if (drain_pause && i == n_items / 2) begin
				pdm.valid <= 1'b0;
				do @(posedge clk); while (pcm_pred.pcm_due.size() != 0);
			end
			if ($urandom_range(0, 99) < idle_pct) pdm_gap($urandom_range(1, 12));
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				pdm_bits = 8'h00;
			end else if (kind == 1) begin
				pdm_bits = 8'hFF;
			end else if (kind <= 4) begin
				pdm_bits = 8'($urandom);
			end else begin
				// density-shaped bitstream, as a real modulator produces
				for (int b = 0; b < 8; b++) pdm_bits[b] = ($urandom_range(0, 15) < density);
			end
			send_pdm(pdm_bits, $urandom_range(0, 24) == 0);
		end
	endtask

	initial begin
		pdm.valid        <= 1'b0;
		pdm.pdm_data     <= '0;
		pdm.block_start  <= 1'b0;
		cfg.valid        <= 1'b0;
		cfg.decim_factor <= '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset factor: one full-scale sample
		rx_idle_pct = 20;
		send_pdm(8'hFF, 1'b1);
		repeat (7) send_pdm(8'hFF, 1'b0);

		// factor 1: eight samples per byte, filter runs into saturation
		wait_pcm_drained(20);
		write_factor(9'd1);
		send_pdm(8'hFF, 1'b1);
		send_pdm(8'hFF, 1'b0);
		send_pdm(8'h00, 1'b0);
		send_pdm(8'h80, 1'b0);
		send_pdm(8'h01, 1'b0);

		// zero factor behaves as one
		wait_pcm_drained(20);
		write_factor(9'd0);
		send_pdm(8'h55, 1'b0);

		// factor above range clamps to 256; bytes that form no sample
		wait_pcm_drained(20);
		write_factor(9'd511);
		send_pdm(8'hFF, 1'b1);
		repeat (3) send_pdm(8'hFF, 1'b0);

		// factor lowered mid-run: raw sample saturates
		wait_pcm_drained(20);
		write_factor(9'd3);
		send_pdm(8'h0F, 1'b0);

		// block start in the middle of a stream
		wait_pcm_drained(20);
		write_factor(9'd2);
		send_pdm(8'hA5, 1'b1);
		send_pdm(8'h3C, 1'b0);

		run_random_phase(9'd5,   44, 25, 1'b0, 1'b0);
		run_random_phase(9'd256, 44, 0,  1'b0, 1'b0);
		run_random_phase(9'd1,   44, 30, 1'b0, 1'b0);
		run_random_phase(9'd3,   44, 15, 1'b1, 1'b0);
		run_random_phase(9'd13,  44, 20, 1'b0, 1'b1);
		run_random_phase(9'd511, 44, 10, 1'b0, 1'b0);
		run_random_phase(9'($urandom_range(2, 64)), 44, 25, 1'b0, 1'b0);
		run_random_phase(9'd8,   44, 0,  1'b0, 1'b0);

		wait_pcm_drained(20);
		repeat (100) @(posedge clk);
		if (pcm_pred.pcm_due.size() != 0) begin
			$error("%0d expected items never arrived", pcm_pred.pcm_due.size());
			pcm_pred.errors++;
		end
		if (pcm_pred.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
